FILE: rtl/blp_pkg.sv
package blp_pkg;

    // Walk sequencer state; doubles as the walk mode of the current line.
    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_STRAIGHT = 2'd1,
        MODE_X_MAJOR  = 2'd2,
        MODE_Y_MAJOR  = 2'd3
    } walk_mode_t;

endpackage

FILE: rtl/bresenham_line_points_top.sv
// Latency: a line request taken on s_axis shows its first point on m_axis in the next cycle.
// Throughput: one point per cycle while m_axis_tready stays high; a new request is not
// taken until the last point of the current line has left on m_axis.
// The single step unit (error add and coordinate step) sets this figure.
// s_axis_tready is high only while no line is being walked.
// Reset (rst_n low, asynchronous): return to idle, drop any line in progress, no output beat.
module bresenham_line_points_top #(
    parameter int COORD_BITS = 6
) (
    input  logic clk,
    input  logic rst_n,

    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // start_x, start_y, end_x, end_y (COORD_BITS each), zero fill to whole bytes
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,

    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // point_x, point_y (COORD_BITS each), zero fill to whole bytes
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // last_point
    output logic m_axis_tlast
);
    import blp_pkg::*;

    localparam int CB          = COORD_BITS;
    localparam int OUT_TDATA_W = ((2*COORD_BITS+7)/8)*8;
    // Error term spans roughly -2*dmajor .. +2*dminor; two guard bits plus sign.
    localparam int ERR_W       = COORD_BITS + 3;
    localparam logic [CB-1:0] ONE = CB'(1);

    // Sequencer state and walk registers
    walk_mode_t              mode_reg, mode_next;
    logic [CB-1:0]           walk_x_reg, walk_x_next;
    logic [CB-1:0]           walk_y_reg, walk_y_next;
    logic [CB-1:0]           target_x_reg, target_x_next;
    logic [CB-1:0]           target_y_reg, target_y_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [CB:0]             maj_twice_reg, maj_twice_next;
    logic [CB:0]             min_twice_reg, min_twice_next;
    logic                    neg_maj_reg, neg_maj_next;
    logic                    neg_min_reg, neg_min_next;

    // Request decode
    logic [CB-1:0] sx, sy, ex, ey;
    logic [CB-1:0] adx, ady;
    logic          negx, negy;
    logic          straight, x_major;

    // Handshakes
    logic in_beat, out_beat, last_pt;

    // Shared step unit
    logic [CB-1:0]           cur_maj, cur_min, nxt_maj, nxt_min;
    logic                    take_minor;
    logic signed [ERR_W-1:0] min_ext, maj_ext, err_step;

    assign sx = s_axis_tdata[CB-1:0];
    assign sy = s_axis_tdata[2*CB-1:CB];
    assign ex = s_axis_tdata[3*CB-1:2*CB];
    assign ey = s_axis_tdata[4*CB-1:3*CB];

    assign negx     = (ex < sx);
    assign negy     = (ey < sy);
    assign adx      = negx ? (sx - ex) : (ex - sx);
    assign ady      = negy ? (sy - ey) : (ey - sy);
    assign straight = (sx == ex) || (sy == ey);
    assign x_major  = (adx >= ady);    // diagonal walks as x-major

    // Final point: both coords for a straight run, the major coord otherwise
    always_comb
    begin
        case (mode_reg)
            MODE_STRAIGHT: last_pt = (walk_x_reg == target_x_reg) &&
                                     (walk_y_reg == target_y_reg);
            MODE_X_MAJOR:  last_pt = (walk_x_reg == target_x_reg);
            MODE_Y_MAJOR:  last_pt = (walk_y_reg == target_y_reg);
            default:       last_pt = 1'b0;
        endcase
    end

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    // Next state
    always_comb
    begin
        mode_next = mode_reg;
        case (mode_reg)
            MODE_IDLE:
            begin
                if (in_beat)
                begin
                    if (straight)
                        mode_next = MODE_STRAIGHT;
                    else if (x_major)
                        mode_next = MODE_X_MAJOR;
                    else
                        mode_next = MODE_Y_MAJOR;
                end
            end
            default:
            begin
                if (out_beat && last_pt)
                    mode_next = MODE_IDLE;
            end
        endcase
    end

    // Port outputs: the walk registers are the output register
    always_comb
    begin
        s_axis_tready = (mode_reg == MODE_IDLE);
        m_axis_tvalid = (mode_reg != MODE_IDLE);
        m_axis_tlast  = last_pt;
        m_axis_tdata  = OUT_TDATA_W'({walk_y_reg, walk_x_reg});
    end

    // Step unit: one error update, a major step and, when taken, a minor step per point
    assign cur_maj    = (mode_reg == MODE_Y_MAJOR) ? walk_y_reg : walk_x_reg;
    assign cur_min    = (mode_reg == MODE_Y_MAJOR) ? walk_x_reg : walk_y_reg;
    // Step the minor axis on a positive error, or on zero with a positive major step
    assign take_minor = (!err_reg[ERR_W-1] && (err_reg != '0)) ||
                        ((err_reg == '0) && !neg_maj_reg);
    assign min_ext    = $signed({2'b00, min_twice_reg});
    assign maj_ext    = take_minor ? $signed({2'b00, maj_twice_reg}) : '0;
    assign err_step   = err_reg + min_ext - maj_ext;
    assign nxt_maj    = neg_maj_reg ? (cur_maj - ONE) : (cur_maj + ONE);
    assign nxt_min    = !take_minor ? cur_min :
                        (neg_min_reg ? (cur_min - ONE) : (cur_min + ONE));

    // Datapath next values
    always_comb
    begin
        walk_x_next    = walk_x_reg;
        walk_y_next    = walk_y_reg;
        target_x_next  = target_x_reg;
        target_y_next  = target_y_reg;
        err_next       = err_reg;
        maj_twice_next = maj_twice_reg;
        min_twice_next = min_twice_reg;
        neg_maj_next   = neg_maj_reg;
        neg_min_next   = neg_min_reg;
        if (in_beat)
        begin
            if (straight)
            begin
                // ascending order whatever the endpoint order
                walk_x_next   = negx ? ex : sx;
                walk_y_next   = negy ? ey : sy;
                target_x_next = negx ? sx : ex;
                target_y_next = negy ? sy : ey;
                err_next      = '0;
            end
            else
            begin
                walk_x_next   = sx;
                walk_y_next   = sy;
                target_x_next = ex;
                target_y_next = ey;
                if (x_major)
                begin
                    maj_twice_next = {adx, 1'b0};
                    min_twice_next = {ady, 1'b0};
                    neg_maj_next   = negx;
                    neg_min_next   = negy;
                    err_next       = $signed({2'b00, ady, 1'b0}) - $signed({3'b000, adx});
                end
                else
                begin
                    maj_twice_next = {ady, 1'b0};
                    min_twice_next = {adx, 1'b0};
                    neg_maj_next   = negy;
                    neg_min_next   = negx;
                    err_next       = $signed({2'b00, adx, 1'b0}) - $signed({3'b000, ady});
                end
            end
        end
        else if (out_beat && !last_pt)
        begin
            case (mode_reg)
                MODE_STRAIGHT:
                begin
                    if (walk_x_reg != target_x_reg)
                        walk_x_next = walk_x_reg + ONE;
                    else
                        walk_y_next = walk_y_reg + ONE;
                end
                MODE_X_MAJOR:
                begin
                    walk_x_next = nxt_maj;
                    walk_y_next = nxt_min;
                    err_next    = err_step;
                end
                MODE_Y_MAJOR:
                begin
                    walk_y_next = nxt_maj;
                    walk_x_next = nxt_min;
                    err_next    = err_step;
                end
                default:
                begin
                    err_next = err_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_IDLE;
        else
            mode_reg <= mode_next;
    end

    // Payload registers: cleared on reset, loaded on the request beat, stepped on each non-final point beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_x_reg    <= '0;
            walk_y_reg    <= '0;
            target_x_reg  <= '0;
            target_y_reg  <= '0;
            err_reg       <= '0;
            maj_twice_reg <= '0;
            min_twice_reg <= '0;
            neg_maj_reg   <= 1'b0;
            neg_min_reg   <= 1'b0;
        end
        else
        begin
            walk_x_reg    <= walk_x_next;
            walk_y_reg    <= walk_y_next;
            target_x_reg  <= target_x_next;
            target_y_reg  <= target_y_next;
            err_reg       <= err_next;
            maj_twice_reg <= maj_twice_next;
            min_twice_reg <= min_twice_next;
            neg_maj_reg   <= neg_maj_next;
            neg_min_reg   <= neg_min_next;
        end
    end

    // A request beat always leaves a point on the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> m_axis_tvalid)
        else $error("no point after request beat");

    // Taking the final point returns the sequencer to idle, which frees the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && m_axis_tlast) |=> s_axis_tready)
        else $error("input not freed after final point");

    // Input and output sides are never both open
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request taken while a line is being walked");

    // A straight run never passes its target
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_STRAIGHT) |-> (walk_x_reg <= target_x_reg) &&
                                        (walk_y_reg <= target_y_reg))
        else $error("straight walk overran its target");

endmodule
